// ===== sv/clcd_pkg.sv =====
// Shared types, constants and helper functions for the character LCD terminal front end.
package clcd_pkg;

    // Display geometry and tab handling.
    localparam int LINE_LEN = 16;
    localparam int TAB_STOP = 4;
    localparam int COL_W    = $clog2(LINE_LEN);
    localparam int CNT_W    = COL_W + 1;
    localparam int TAB_K_W  = 3;
    localparam logic [TAB_K_W-1:0] TAB_CAP = 3'd4;

    typedef logic [6:0] t_addr;

    // Line start addresses in display order, and the phantom pinned addresses.
    localparam logic [3:0][6:0] LINE_START = {7'h50, 7'h10, 7'h40, 7'h00};
    localparam logic [3:0][6:0] PIN_END    = {7'h61, 7'h60, 7'h21, 7'h20};
    localparam logic [3:0][6:0] PIN_START  = {7'h26, 7'h27, 7'h66, 7'h67};

    // Text byte codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Escape sequence codes.
    localparam logic [7:0] ESC_CUR_OFF    = 8'h61;
    localparam logic [7:0] ESC_BLINK      = 8'h62;
    localparam logic [7:0] ESC_CUR_ON     = 8'h76;
    localparam logic [7:0] ESC_CUR_HIDE   = 8'h56;
    localparam logic [7:0] ESC_HOME       = 8'h48;
    localparam logic [7:0] ESC_CLEAR      = 8'h4A;
    localparam logic [7:0] ESC_UP         = 8'h41;
    localparam logic [7:0] ESC_DOWN       = 8'h42;
    localparam logic [7:0] ESC_RIGHT      = 8'h43;
    localparam logic [7:0] ESC_LEFT       = 8'h44;
    localparam logic [7:0] ESC_MARGIN_ON  = 8'h6D;
    localparam logic [7:0] ESC_MARGIN_OFF = 8'h4D;

    // Controller instruction codes.
    localparam logic [7:0] INS_CLEAR    = 8'h01;
    localparam logic [7:0] INS_HOME     = 8'h02;
    localparam logic       INS_SET_ADDR = 1'b1;
    localparam logic [4:0] INS_DISP_CTL = 5'b00001;
    localparam logic       DISP_ON      = 1'b1;
    localparam logic       RS_INSTR     = 1'b0;
    localparam logic       RS_DATA      = 1'b1;

    // Channel words.
    typedef struct packed {
        logic [7:0] char_in;
        logic       last_of_write;
    } t_in_word;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_byte;
        logic       last;
    } t_out_word;

    // Sequencer to output stage: one result byte or the end of an item.
    typedef struct packed {
        logic       push;
        logic       finish;
        logic       rs;
        logic [7:0] bus_byte;
    } t_emit_req;

    // Output stage status back to the sequencer.
    typedef struct packed {
        logic go;
        logic hold_v;
    } t_stage_stat;

    typedef struct packed {
        logic  hit;
        t_addr target;
    } t_pin_info;

    typedef struct packed {
        logic  emit;
        t_addr addr;
    } t_step_res;

    // Columns that are tab stops, worked out at elaboration.
    function automatic logic [LINE_LEN-1:0] tab_hit_mask();
        logic [LINE_LEN-1:0] m;
        for (int j = 0; j < LINE_LEN; j++) begin
            m[j] = ((j % TAB_STOP) == 0);
        end
        return m;
    endfunction

    localparam logic [LINE_LEN-1:0] TAB_HIT = tab_hit_mask();

    // A pinned address resolves to the line end or start it stands for.
    function automatic t_pin_info pin_lookup(t_addr a);
        t_pin_info p;
        p.hit    = 1'b0;
        p.target = a;
        for (int i = 0; i < 4; i++) begin
            if (a == PIN_END[i]) begin
                p.hit    = 1'b1;
                p.target = LINE_START[i] + t_addr'(LINE_LEN - 1);
            end
            if (a == PIN_START[i]) begin
                p.hit    = 1'b1;
                p.target = LINE_START[i];
            end
        end
        return p;
    endfunction

    // One cursor step; at a line edge it wraps or pins and needs a set-address.
    function automatic t_step_res step_calc(t_addr a, logic fwd, logic am);
        t_step_res r;
        r.emit = 1'b0;
        r.addr = fwd ? a + 7'd1 : a - 7'd1;
        for (int i = 0; i < 4; i++) begin
            if (fwd && (a == LINE_START[i] + t_addr'(LINE_LEN - 1))) begin
                r.emit = 1'b1;
                r.addr = am ? t_addr'(LINE_START[2'(i + 1)]) : t_addr'(PIN_END[i]);
            end
            if (!fwd && (a == LINE_START[i])) begin
                r.emit = 1'b1;
                r.addr = am ? LINE_START[2'(i + 3)] + t_addr'(LINE_LEN - 1)
                            : t_addr'(PIN_START[i]);
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/char_lcd_terminal_frontend_unit.sv =====
// Top level of the character LCD terminal front end: byte decoder and cursor sequencer.
//
// Text bytes arrive on the input channel (i_in_valid / o_in_ready, word i_in_word) and the
// instruction and data bytes for a 4x16 character display leave on the output channel
// (o_out_valid / i_out_ready, word o_out_word), one result word per handshake, with last
// set on the final word that one input byte causes. Bytes that cause nothing (ESC, NUL,
// skipped bytes, margin-off, unknown escapes) produce no word. A byte is taken only while
// the sequencer is idle. A newline or vertical move takes 16 steps of the shared cursor
// stepper. The final word of a byte moves from the hold stage into the output register
// when the sequencer finishes the byte, and the next byte can be accepted while that word
// still waits. A stalled receiver holds the sequencer once both the output register and
// the one-word hold stage are full; nothing is dropped. Synchronous active-low reset puts
// the cursor at address 0 with margins on, cursor and blink off, and empties both output
// stages.
module char_lcd_terminal_frontend_unit
    import clcd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_UNPIN     = 14'b00000000000010,
        S_STEP      = 14'b00000000000100,
        S_FINAL     = 14'b00000000001000,
        S_PUT       = 14'b00000000010000,
        S_ADV       = 14'b00000000100000,
        S_COL       = 14'b00000001000000,
        S_CLR       = 14'b00000010000000,
        S_HOME      = 14'b00000100000000,
        S_HOME_ADDR = 14'b00001000000000,
        S_CTL2      = 14'b00010000000000,
        S_CTL       = 14'b00100000000000,
        S_MON       = 14'b01000000000000,
        S_DONE      = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    t_addr  r_addr, n_addr;
    logic   r_am, n_am;
    logic   r_cv, n_cv;
    logic   r_blink, n_blink;
    logic   r_esc, n_esc;
    logic   r_skip, n_skip;

    logic [7:0]         r_char, n_char;
    logic               r_dir, n_dir;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_is_cr, n_is_cr;
    logic               r_is_tab, n_is_tab;
    logic [TAB_K_W-1:0] r_tab_k, n_tab_k;

    t_emit_req   w_req;
    t_stage_stat w_stat;
    t_pin_info   w_pin;
    t_addr       w_res_addr;
    t_step_res   w_mv;
    t_step_res   w_adv;
    logic        w_go;
    logic [7:0]  w_ctl_byte;

    // Shared cursor logic: pin resolve and one wrap-aware step.
    assign w_pin      = pin_lookup(r_addr);
    assign w_res_addr = (!r_am && w_pin.hit) ? w_pin.target : r_addr;
    assign w_mv       = step_calc(r_addr, r_dir, 1'b1);
    assign w_adv      = step_calc(r_addr, 1'b1, r_am);
    assign w_go       = w_stat.go;
    assign w_ctl_byte = {INS_DISP_CTL, DISP_ON, r_cv, r_blink};
    assign o_in_ready = (r_state == S_IDLE);

    // Decoder and sequencer.
    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_am     = r_am;
        n_cv     = r_cv;
        n_blink  = r_blink;
        n_esc    = r_esc;
        n_skip   = r_skip;
        n_char   = r_char;
        n_dir    = r_dir;
        n_cnt    = r_cnt;
        n_is_cr  = r_is_cr;
        n_is_tab = r_is_tab;
        n_tab_k  = r_tab_k;
        w_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_is_cr  = 1'b0;
                    n_is_tab = 1'b0;
                    if (r_skip || (i_in_word.char_in == CH_NUL)) begin
                        n_skip = !i_in_word.last_of_write;
                    end else if (r_esc) begin
                        n_esc = 1'b0;
                        unique case (i_in_word.char_in)
                            ESC_CUR_OFF: begin
                                n_cv    = 1'b0;
                                n_state = S_CTL2;
                            end
                            ESC_BLINK: begin
                                n_blink = 1'b1;
                                n_state = S_CTL;
                            end
                            ESC_CUR_ON: begin
                                n_cv    = 1'b1;
                                n_state = S_CTL;
                            end
                            ESC_CUR_HIDE: begin
                                n_cv    = 1'b0;
                                n_state = S_CTL;
                            end
                            ESC_HOME:  n_state = S_HOME;
                            ESC_CLEAR: n_state = S_CLR;
                            ESC_DOWN: begin
                                n_dir   = 1'b1;
                                n_cnt   = CNT_W'(LINE_LEN);
                                n_state = S_UNPIN;
                            end
                            ESC_UP: begin
                                n_dir   = 1'b0;
                                n_cnt   = CNT_W'(LINE_LEN);
                                n_state = S_UNPIN;
                            end
                            ESC_RIGHT: begin
                                n_dir   = 1'b1;
                                n_cnt   = CNT_W'(1);
                                n_state = S_UNPIN;
                            end
                            ESC_LEFT: begin
                                n_dir   = 1'b0;
                                n_cnt   = CNT_W'(1);
                                n_state = S_UNPIN;
                            end
                            ESC_MARGIN_ON:  n_state = S_MON;
                            ESC_MARGIN_OFF: n_am = 1'b0;
                            default: ;
                        endcase
                    end else begin
                        unique case (i_in_word.char_in)
                            CH_ESC: n_esc = 1'b1;
                            CH_LF: begin
                                n_dir   = 1'b1;
                                n_cnt   = CNT_W'(LINE_LEN);
                                n_state = S_UNPIN;
                            end
                            CH_CR: begin
                                n_dir   = 1'b0;
                                n_is_cr = 1'b1;
                                n_state = S_UNPIN;
                            end
                            CH_TAB: begin
                                n_char   = CH_SPACE;
                                n_is_tab = 1'b1;
                                n_tab_k  = '0;
                                n_state  = S_PUT;
                            end
                            CH_BS: begin
                                n_dir   = 1'b0;
                                n_cnt   = CNT_W'(1);
                                n_state = S_UNPIN;
                            end
                            default: begin
                                n_char  = i_in_word.char_in;
                                n_state = S_PUT;
                            end
                        endcase
                    end
                end
            end

            // Leave a pinned address before a move; CR takes its step count here.
            S_UNPIN: begin
                if (w_go) begin
                    if (!r_am && w_pin.hit) begin
                        w_req.push     = 1'b1;
                        w_req.rs       = RS_INSTR;
                        w_req.bus_byte = {INS_SET_ADDR, w_pin.target};
                    end
                    n_addr = w_res_addr;
                    if (r_is_cr) begin
                        n_cnt = CNT_W'(w_res_addr[COL_W-1:0]);
                    end
                    n_state = S_STEP;
                end
            end

            // One cursor step per cycle with margins on, unless the output stage holds the sequencer.
            S_STEP: begin
                if (w_go) begin
                    if (r_cnt == '0) begin
                        n_state = S_FINAL;
                    end else begin
                        if (w_mv.emit) begin
                            w_req.push     = 1'b1;
                            w_req.rs       = RS_INSTR;
                            w_req.bus_byte = {INS_SET_ADDR, w_mv.addr};
                        end
                        n_addr = w_mv.addr;
                        n_cnt  = r_cnt - CNT_W'(1);
                    end
                end
            end

            S_FINAL: begin
                if (w_go) begin
                    w_req.push     = 1'b1;
                    w_req.rs       = RS_INSTR;
                    w_req.bus_byte = {INS_SET_ADDR, r_addr};
                    n_state        = S_DONE;
                end
            end

            S_PUT: begin
                if (w_go) begin
                    w_req.push     = 1'b1;
                    w_req.rs       = RS_DATA;
                    w_req.bus_byte = r_char;
                    n_tab_k        = r_tab_k + TAB_K_W'(1);
                    n_state        = S_ADV;
                end
            end

            // Advance after a character with the current margin mode.
            S_ADV: begin
                if (w_go) begin
                    if (!r_am && w_pin.hit) begin
                        w_req.push     = 1'b1;
                        w_req.rs       = RS_INSTR;
                        w_req.bus_byte = {INS_SET_ADDR, r_addr};
                    end else begin
                        if (w_adv.emit) begin
                            w_req.push     = 1'b1;
                            w_req.rs       = RS_INSTR;
                            w_req.bus_byte = {INS_SET_ADDR, w_adv.addr};
                        end
                        n_addr = w_adv.addr;
                    end
                    n_state = r_is_tab ? S_COL : S_DONE;
                end
            end

            // Tab: resolve a pin, then stop at a tab column or after the space cap.
            S_COL: begin
                if (w_go) begin
                    if (!r_am && w_pin.hit) begin
                        w_req.push     = 1'b1;
                        w_req.rs       = RS_INSTR;
                        w_req.bus_byte = {INS_SET_ADDR, w_pin.target};
                    end
                    n_addr = w_res_addr;
                    if (TAB_HIT[w_res_addr[COL_W-1:0]] || (r_tab_k == TAB_CAP)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_PUT;
                    end
                end
            end

            S_CLR: begin
                if (w_go) begin
                    w_req.push     = 1'b1;
                    w_req.rs       = RS_INSTR;
                    w_req.bus_byte = INS_CLEAR;
                    n_state        = S_HOME;
                end
            end

            S_HOME: begin
                if (w_go) begin
                    w_req.push     = 1'b1;
                    w_req.rs       = RS_INSTR;
                    w_req.bus_byte = INS_HOME;
                    n_state        = S_HOME_ADDR;
                end
            end

            S_HOME_ADDR: begin
                if (w_go) begin
                    w_req.push     = 1'b1;
                    w_req.rs       = RS_INSTR;
                    w_req.bus_byte = {INS_SET_ADDR, 7'h00};
                    n_addr         = '0;
                    n_state        = S_DONE;
                end
            end

            // Cursor off first, then blink off.
            S_CTL2: begin
                if (w_go) begin
                    w_req.push     = 1'b1;
                    w_req.rs       = RS_INSTR;
                    w_req.bus_byte = w_ctl_byte;
                    n_blink        = 1'b0;
                    n_state        = S_CTL;
                end
            end

            S_CTL: begin
                if (w_go) begin
                    w_req.push     = 1'b1;
                    w_req.rs       = RS_INSTR;
                    w_req.bus_byte = w_ctl_byte;
                    n_state        = S_DONE;
                end
            end

            // Margins on: a pinned cursor moves to the line end or start.
            S_MON: begin
                if (w_go) begin
                    if (!r_am && w_pin.hit) begin
                        w_req.push     = 1'b1;
                        w_req.rs       = RS_INSTR;
                        w_req.bus_byte = {INS_SET_ADDR, w_pin.target};
                    end
                    n_addr  = w_res_addr;
                    n_am    = 1'b1;
                    n_state = S_DONE;
                end
            end

            // Release the held word as the last one of this byte.
            S_DONE: begin
                if (w_go) begin
                    w_req.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
            r_am    <= 1'b1;
            r_cv    <= 1'b0;
            r_blink <= 1'b0;
            r_esc   <= 1'b0;
            r_skip  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_am    <= n_am;
            r_cv    <= n_cv;
            r_blink <= n_blink;
            r_esc   <= n_esc;
            r_skip  <= n_skip;
        end
    end

    // Per-byte work registers.
    always_ff @(posedge i_clk) begin
        r_char   <= n_char;
        r_dir    <= n_dir;
        r_cnt    <= n_cnt;
        r_is_cr  <= n_is_cr;
        r_is_tab <= n_is_tab;
        r_tab_k  <= n_tab_k;
    end

    clcd_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // The hold stage is empty whenever a new byte can be taken.
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_stat.hold_v)
        else $error("hold stage still full while idle");

    // With margins on the cursor never sits at a phantom address.
    a_margin_unpinned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_am |-> !w_pin.hit)
        else $error("cursor pinned while margins are on");

    // A tab has written between one and four spaces when its column is checked.
    a_tab_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL) |-> ((r_tab_k != '0) && (r_tab_k <= TAB_CAP)))
        else $error("tab space count out of range");

endmodule

// ===== sv/clcd_out_stage.sv =====
// Output staging: holds the newest result until its last flag is known, then registers it.
module clcd_out_stage
    import clcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_emit_req   i_req,
    output t_stage_stat o_stat,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word
);

    logic       r_hold_v;
    logic       r_hold_rs;
    logic [7:0] r_hold_byte;
    logic       r_out_v;
    t_out_word  r_out;

    logic w_out_free;
    logic w_go;
    logic w_push;
    logic w_finish;
    logic w_move;

    // The held word moves out when a newer one arrives or the item ends.
    assign w_out_free = !r_out_v || i_out_ready;
    assign w_go       = !r_hold_v || w_out_free;
    assign w_push     = i_req.push && w_go;
    assign w_finish   = i_req.finish && w_go;
    assign w_move     = r_hold_v && (w_push || w_finish);

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_push) begin
                r_hold_v <= 1'b1;
            end else if (w_finish) begin
                r_hold_v <= 1'b0;
            end
            if (w_move) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Word contents.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_hold_rs   <= i_req.rs;
            r_hold_byte <= i_req.bus_byte;
        end
        if (w_move) begin
            r_out.reg_select <= r_hold_rs;
            r_out.bus_byte   <= r_hold_byte;
            r_out.last       <= w_finish;
        end
    end

    assign o_stat.go     = w_go;
    assign o_stat.hold_v = r_hold_v;
    assign o_out_valid   = r_out_v;
    assign o_out_word    = r_out;

endmodule

// ===== sim/char_lcd_terminal_frontend_unit_test.sv =====
// Self-checking testbench for the character LCD terminal front end.
module char_lcd_terminal_frontend_unit_test;
    import clcd_pkg::*;

    localparam int MAX_WORDS   = 12;
    localparam int STALL_LIMIT = 2000;
    localparam int END_CYCLES  = 40;
    localparam int RANDOM_BYTES = 420;

    // One pending text byte; hold makes the sender wait until every expected word has come.
    typedef struct packed {
        logic     hold;
        t_in_word w;
    } t_text_item;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    logic      in_taken = 1'b0;
    int        bytes_taken = 0;
    int        errors = 0;
    int        stall_cycles = 0;
    logic      hold_next = 1'b0;

    t_text_item text_q[$];
    t_out_word  lcd_word_q[$];

    // Display state as the block should hold it.
    logic      esc_pend;
    t_addr     cursor;
    logic      margins_on;
    logic      disp_on;
    logic      cur_vis;
    logic      blink_on;
    logic      skip_rest;
    int        words_this_byte;

    logic [7:0] esc_codes [12];

    char_lcd_terminal_frontend_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    // Clock with a period of two time units.
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Expected-word helpers. At most MAX_WORDS words come from one text byte.
    task automatic queue_lcd_word(input logic rs, input logic [7:0] b);
        t_out_word w;
        if (words_this_byte < MAX_WORDS) begin
            w.reg_select = rs;
            w.bus_byte   = b;
            w.last       = 1'b0;
            lcd_word_q.push_back(w);
            words_this_byte++;
        end
    endtask

    task automatic set_address(input t_addr a);
        queue_lcd_word(RS_INSTR, {INS_SET_ADDR, a});
        cursor = a;
    endtask

    task automatic send_disp_ctl();
        queue_lcd_word(RS_INSTR, {INS_DISP_CTL, disp_on, cur_vis, blink_on});
    endtask

    function automatic logic addr_is_pinned(input t_addr a);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (a == PIN_END[i] || a == PIN_START[i]) hit = 1'b1;
        end
        return hit;
    endfunction

    // Turning margins on pulls a pinned cursor back to the line end or start.
    task automatic apply_margin(input logic on);
        logic done;
        done = 1'b0;
        if (on && !margins_on) begin
            for (int i = 0; i < 4; i++) begin
                if (!done && cursor == PIN_END[i]) begin
                    set_address(LINE_START[i] + t_addr'(LINE_LEN - 1));
                    done = 1'b1;
                end
                if (!done && cursor == PIN_START[i]) begin
                    set_address(LINE_START[i]);
                    done = 1'b1;
                end
            end
        end
        margins_on = on;
    endtask

    task automatic cursor_fwd();
        int   n;
        logic done;
        done = 1'b0;
        if (!margins_on && addr_is_pinned(cursor)) begin
            set_address(cursor);
        end else begin
            n = int'(cursor) + 1;
            for (int i = 0; i < 4; i++) begin
                if (!done && n == int'(LINE_START[i]) + LINE_LEN) begin
                    if (margins_on) set_address(LINE_START[(i + 1) % 4]);
                    else set_address(PIN_END[i]);
                    done = 1'b1;
                end
            end
            if (!done) cursor = t_addr'(n);
        end
    endtask

    task automatic cursor_back();
        int   n;
        logic done;
        done = 1'b0;
        if (!margins_on && addr_is_pinned(cursor)) begin
            set_address(cursor);
        end else begin
            n = int'(cursor) - 1;
            for (int i = 0; i < 4; i++) begin
                if (!done && n == int'(LINE_START[i]) - 1) begin
                    if (margins_on) begin
                        set_address(LINE_START[(i + 3) % 4] + t_addr'(LINE_LEN - 1));
                    end else begin
                        set_address(PIN_START[i]);
                    end
                    done = 1'b1;
                end
            end
            if (!done) cursor = t_addr'(n);
        end
    endtask

    // Relative moves step with margins on, then restore the mode and set the address.
    task automatic move_by(input int dp);
        logic saved;
        saved = margins_on;
        if (dp < 0) begin
            apply_margin(1'b1);
            repeat (-dp) cursor_back();
            apply_margin(saved);
        end else if (dp > 0) begin
            apply_margin(1'b1);
            repeat (dp) cursor_fwd();
            apply_margin(saved);
        end
        set_address(cursor);
    endtask

    // Reading the column resolves a pinned cursor as a side effect.
    task automatic column_now(output logic [3:0] col);
        logic saved;
        saved = margins_on;
        apply_margin(1'b1);
        col = cursor[3:0];
        apply_margin(saved);
    endtask

    task automatic put_text(input logic [7:0] c);
        queue_lcd_word(RS_DATA, c);
        cursor_fwd();
    endtask

    task automatic home_cursor();
        queue_lcd_word(RS_INSTR, INS_HOME);
        cursor = '0;
        set_address(cursor);
    endtask

    task automatic do_escape_code(input logic [7:0] c);
        case (c)
            ESC_CUR_OFF: begin
                cur_vis = 1'b0;
                send_disp_ctl();
                blink_on = 1'b0;
                send_disp_ctl();
            end
            ESC_BLINK: begin
                blink_on = 1'b1;
                send_disp_ctl();
            end
            ESC_CUR_ON: begin
                cur_vis = 1'b1;
                send_disp_ctl();
            end
            ESC_CUR_HIDE: begin
                cur_vis = 1'b0;
                send_disp_ctl();
            end
            ESC_HOME: home_cursor();
            ESC_CLEAR: begin
                queue_lcd_word(RS_INSTR, INS_CLEAR);
                home_cursor();
            end
            ESC_DOWN:       move_by(LINE_LEN);
            ESC_UP:         move_by(-LINE_LEN);
            ESC_LEFT:       move_by(-1);
            ESC_RIGHT:      move_by(1);
            ESC_MARGIN_ON:  apply_margin(1'b1);
            ESC_MARGIN_OFF: apply_margin(1'b0);
            default: ;
        endcase
    endtask

    task automatic do_text_byte(input logic [7:0] c);
        logic [3:0] col;
        int         k;
        case (c)
            CH_ESC: esc_pend = 1'b1;
            CH_LF:  move_by(LINE_LEN);
            CH_CR: begin
                column_now(col);
                move_by(-int'(col));
            end
            CH_TAB: begin
                // Spaces up to the next tab stop, never more than the cap.
                k = 0;
                do begin
                    put_text(CH_SPACE);
                    column_now(col);
                    k++;
                end while ((int'(col) % TAB_STOP) != 0 && k < int'(TAB_CAP));
            end
            CH_BS:  move_by(-1);
            default: put_text(c);
        endcase
    endtask

    // Works out the words that one accepted text byte causes.
    task automatic render_byte(input t_in_word w);
        t_out_word tail;
        words_this_byte = 0;
        if (skip_rest || w.char_in == CH_NUL) begin
            skip_rest = !w.last_of_write;
        end else begin
            if (esc_pend) begin
                esc_pend = 1'b0;
                do_escape_code(w.char_in);
            end else begin
                do_text_byte(w.char_in);
            end
            if (w.last_of_write) skip_rest = 1'b0;
            if (words_this_byte > 0) begin
                tail = lcd_word_q.pop_back();
                tail.last = 1'b1;
                lcd_word_q.push_back(tail);
            end
        end
    endtask

    // Stimulus helpers.
    task automatic add_byte(input logic [7:0] c, input logic lw);
        t_text_item it;
        it.hold            = hold_next;
        it.w.char_in       = c;
        it.w.last_of_write = lw;
        text_q.push_back(it);
        hold_next = 1'b0;
    endtask

    function automatic logic rand_last();
        return ($urandom_range(0, 4) == 0);
    endfunction

    task automatic add_esc(input logic [7:0] code);
        add_byte(CH_ESC, rand_last());
        add_byte(code, 1'b1);
    endtask

    // One random chunk: mostly well-formed text and escapes, some noise.
    task automatic add_random_chunk();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            add_byte(8'($urandom_range(32, 126)), rand_last());
        end else if (r < 45) begin
            add_byte(8'($urandom_range(0, 255)), rand_last());
        end else if (r < 52) begin
            add_byte(CH_LF, rand_last());
        end else if (r < 57) begin
            add_byte(CH_CR, rand_last());
        end else if (r < 63) begin
            add_byte(CH_TAB, rand_last());
        end else if (r < 68) begin
            add_byte(CH_BS, rand_last());
        end else if (r < 88) begin
            add_byte(CH_ESC, rand_last());
            add_byte(esc_codes[$urandom_range(0, 11)], rand_last());
        end else if (r < 91) begin
            add_byte(CH_ESC, rand_last());
            add_byte(8'($urandom_range(0, 255)), rand_last());
        end else if (r < 94) begin
            add_byte(CH_NUL, rand_last());
        end else begin
            // Margins off and a run of text, so the cursor reaches a pinned line end.
            add_byte(CH_ESC, 1'b0);
            add_byte(ESC_MARGIN_OFF, 1'b0);
            len = $urandom_range(8, 20);
            for (int j = 0; j < len; j++) begin
                add_byte(8'($urandom_range(32, 126)), rand_last());
            end
            if ($urandom_range(0, 1) == 0) add_esc(ESC_MARGIN_ON);
        end
    endtask

    // Driver: text bytes and output ready change at the falling edge.
    always @(negedge clk) begin : feed
        t_text_item it;
        logic       quiet;
        quiet = (bytes_taken >= 150 && bytes_taken < 260);
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            out_ready <= quiet || ($urandom_range(0, 99) >= 6);
            if (!in_valid || in_taken) begin
                if (text_q.size() != 0) begin
                    it = text_q[0];
                end else begin
                    it = '0;
                end
                if (text_q.size() != 0 && !(it.hold && lcd_word_q.size() != 0) &&
                    (quiet || $urandom_range(0, 99) >= 6)) begin
                    it = text_q.pop_front();
                    in_word  <= it.w;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predicts on each accepted byte and checks each accepted word.
    always @(posedge clk) begin : watch
        t_out_word want;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                render_byte(in_word);
                bytes_taken++;
            end
            if (out_valid && out_ready) begin
                if (lcd_word_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word: expected none, actual rs=%0b byte=%h last=%0b",
                             $time, out_word.reg_select, out_word.bus_byte, out_word.last);
                end else begin
                    want = lcd_word_q.pop_front();
                    if (want.reg_select !== out_word.reg_select ||
                        want.bus_byte !== out_word.bus_byte ||
                        want.last !== out_word.last) begin
                        errors++;
                        $display("%0t: word differs: expected rs=%0b byte=%h last=%0b, actual rs=%0b byte=%h last=%0b",
                                 $time, want.reg_select, want.bus_byte, want.last,
                                 out_word.reg_select, out_word.bus_byte, out_word.last);
                    end
                end
            end
        end
    end

    // Watchdog: too many cycles without any handshake ends the run.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("char_lcd_terminal_frontend_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int n_random;
        esc_codes = '{ESC_CUR_OFF, ESC_BLINK, ESC_CUR_ON, ESC_CUR_HIDE, ESC_HOME, ESC_CLEAR,
                      ESC_UP, ESC_DOWN, ESC_RIGHT, ESC_LEFT, ESC_MARGIN_ON, ESC_MARGIN_OFF};

        // Predictor state after reset.
        esc_pend   = 1'b0;
        cursor     = '0;
        margins_on = 1'b1;
        disp_on    = DISP_ON;
        cur_vis    = 1'b0;
        blink_on   = 1'b0;
        skip_rest  = 1'b0;

        // Directed bytes: clear, high byte, NUL skipping a write, display control,
        // tab, backspace, CR, newline, moves with margins off, unknown escape, margins on, home.
        add_esc(ESC_CLEAR);
        add_byte(8'hFF, 1'b1);
        add_byte(CH_NUL, 1'b0);
        add_byte("x", 1'b1);
        add_esc(ESC_CUR_ON);
        add_esc(ESC_BLINK);
        add_esc(ESC_CUR_OFF);
        add_byte(CH_TAB, 1'b1);
        add_byte(CH_BS, 1'b1);
        add_byte(CH_CR, 1'b1);
        add_byte(CH_LF, 1'b1);
        add_esc(ESC_MARGIN_OFF);
        add_esc(ESC_UP);
        add_esc(ESC_LEFT);
        add_esc(8'h7A);
        add_esc(ESC_MARGIN_ON);
        add_esc(ESC_HOME);

        // Random part; the sender drains the block first at its start and around the 210th byte.
        n_random = 0;
        while (n_random < RANDOM_BYTES) begin
            if (n_random == 0 || (n_random >= 210 && n_random < 215)) hold_next = 1'b1;
            n_random = n_random - text_q.size();
            add_random_chunk();
            n_random = n_random + text_q.size();
        end

        // Reset is released at a falling edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (text_q.size() != 0 || in_valid || lcd_word_q.size() != 0) @(posedge clk);
        repeat (END_CYCLES) @(negedge clk);
        if (errors == 0) begin
            $display("char_lcd_terminal_frontend_unit: match");
        end else begin
            $display("char_lcd_terminal_frontend_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/clcd_pkg.sv
sv/clcd_out_stage.sv
sv/char_lcd_terminal_frontend_unit.sv
sim/char_lcd_terminal_frontend_unit_test.sv
